FILE: hdl/bgfd_pkg.sv
package bgfd_pkg;

   // frame parser phases
   localparam logic [3:0] PH_HUNT1   = 4'd0;
   localparam logic [3:0] PH_HUNT2   = 4'd1;
   localparam logic [3:0] PH_CLASS   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CK_A    = 4'd7;
   localparam logic [3:0] PH_CK_B    = 4'd8;

   // register indexes
   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN     = 2'd2;

   // register reset values
   localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
   localparam logic [15:0] MAX_LEN_RST     = 16'd4096;

   typedef struct packed {
      logic        is_frame_end;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_len;
      logic        frame_status;
      logic [31:0] good_frames;
   } rsp_type;

endpackage

FILE: hdl/binary_gnss_frame_decoder.sv
// channel  ports                      dir  notes
// req      req_valid/req_stall        in   req_rx_byte, one received byte
// rsp      rsp_valid/rsp_stall        out  payload byte or end-of-frame result
// csr      csr_valid/csr_ready        in   csr_index, csr_wdata; ready tied high
//
// One byte per cycle: the parser state, the running Fletcher sums and any
// result register all update on the accepting edge, so a result enters the
// output register or the skid. With rsp_stall low a byte is taken every cycle.
// A skid register behind the output lets one more transaction in while a
// result is stalled; req_stall rises only once the skid holds a result.
// Reset (synchronous, active high) returns the parser to the sync hunt,
// clears the sums and good-frame count and restores the register defaults.
module binary_gnss_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_frame_end,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_byte_index,
   output logic [7:0]  rsp_msg_class,
   output logic [7:0]  rsp_msg_id,
   output logic [15:0] rsp_payload_len,
   output logic        rsp_frame_status,
   output logic [31:0] rsp_good_frames,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   logic [7:0]  sync_first_ff;
   logic [7:0]  sync_second_ff;
   logic [15:0] max_len_ff;

   // parser state
   logic [3:0]  phase_ff,      phase_in;
   logic [7:0]  cur_class_ff,  cur_class_in;
   logic [7:0]  cur_id_ff,     cur_id_in;
   logic [15:0] cur_len_ff,    cur_len_in;
   logic [15:0] bytes_seen_ff, bytes_seen_in;
   logic [7:0]  sum_a_ff,      sum_a_in;
   logic [7:0]  sum_b_ff,      sum_b_in;
   logic [7:0]  rx_check_a_ff, rx_check_a_in;
   logic [31:0] good_count_ff, good_count_in;

   // output stage and skid
   logic                  rsp_valid_ff;
   logic                  skid_valid_ff;
   bgfd_pkg::rsp_type     rsp_ff;
   bgfd_pkg::rsp_type     skid_ff;
   bgfd_pkg::rsp_type     res;
   logic                  res_valid;

   logic        accept;
   logic        out_free;
   logic [7:0]  add_a;
   logic [7:0]  add_b;
   logic [15:0] len_full;
   logic [15:0] seen_next;
   logic        cks_ok;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= bgfd_pkg::SYNC_FIRST_RST;
         sync_second_ff <= bgfd_pkg::SYNC_SECOND_RST;
         max_len_ff     <= bgfd_pkg::MAX_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bgfd_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata[7:0];
            bgfd_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_wdata[7:0];
            bgfd_pkg::CSR_MAX_LEN:     max_len_ff     <= csr_wdata;
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   // Fletcher step on the incoming byte
   assign add_a     = sum_a_ff + req_rx_byte;
   assign add_b     = sum_b_ff + add_a;
   assign len_full  = {req_rx_byte, cur_len_ff[7:0]};
   assign seen_next = bytes_seen_ff + 16'd1;
   assign cks_ok    = (rx_check_a_ff == sum_a_ff) && (req_rx_byte == sum_b_ff);

   always_comb begin
      phase_in      = phase_ff;
      cur_class_in  = cur_class_ff;
      cur_id_in     = cur_id_ff;
      cur_len_in    = cur_len_ff;
      bytes_seen_in = bytes_seen_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      rx_check_a_in = rx_check_a_ff;
      good_count_in = good_count_ff;
      res_valid     = 1'b0;

      unique case (phase_ff)
         bgfd_pkg::PH_HUNT2: begin
            // second sync compared first, so equal sync values still lock
            if (req_rx_byte == sync_second_ff) begin
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
               phase_in = bgfd_pkg::PH_CLASS;
            end else if (req_rx_byte != sync_first_ff) begin
               phase_in = bgfd_pkg::PH_HUNT1;
            end
         end
         bgfd_pkg::PH_CLASS: begin
            cur_class_in = req_rx_byte;
            sum_a_in     = add_a;
            sum_b_in     = add_b;
            phase_in     = bgfd_pkg::PH_ID;
         end
         bgfd_pkg::PH_ID: begin
            cur_id_in = req_rx_byte;
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            phase_in  = bgfd_pkg::PH_LEN_LO;
         end
         bgfd_pkg::PH_LEN_LO: begin
            cur_len_in = {8'd0, req_rx_byte};
            sum_a_in   = add_a;
            sum_b_in   = add_b;
            phase_in   = bgfd_pkg::PH_LEN_HI;
         end
         bgfd_pkg::PH_LEN_HI: begin
            cur_len_in    = len_full;
            sum_a_in      = add_a;
            sum_b_in      = add_b;
            bytes_seen_in = 16'd0;
            if (len_full > max_len_ff) begin
               phase_in = bgfd_pkg::PH_HUNT1;
            end else if (len_full == 16'd0) begin
               phase_in = bgfd_pkg::PH_CK_A;
            end else begin
               phase_in = bgfd_pkg::PH_PAYLOAD;
            end
         end
         bgfd_pkg::PH_PAYLOAD: begin
            res_valid     = 1'b1;
            sum_a_in      = add_a;
            sum_b_in      = add_b;
            bytes_seen_in = seen_next;
            if (seen_next >= cur_len_ff) begin
               phase_in = bgfd_pkg::PH_CK_A;
            end
         end
         bgfd_pkg::PH_CK_A: begin
            rx_check_a_in = req_rx_byte;
            phase_in      = bgfd_pkg::PH_CK_B;
         end
         bgfd_pkg::PH_CK_B: begin
            res_valid = 1'b1;
            if (cks_ok) begin
               good_count_in = good_count_ff + 32'd1;
            end
            phase_in = bgfd_pkg::PH_HUNT1;
         end
         default: begin
            // hunt, and any unused code behaves as hunt
            phase_in = (req_rx_byte == sync_first_ff) ? bgfd_pkg::PH_HUNT2
                                                      : bgfd_pkg::PH_HUNT1;
         end
      endcase

      res.is_frame_end = (phase_ff == bgfd_pkg::PH_CK_B);
      res.payload_byte = res.is_frame_end ? 8'd0 : req_rx_byte;
      res.byte_index   = res.is_frame_end ? 16'd0 : bytes_seen_ff;
      res.msg_class    = cur_class_ff;
      res.msg_id       = cur_id_ff;
      res.payload_len  = cur_len_ff;
      res.frame_status = res.is_frame_end && !cks_ok;
      res.good_frames  = good_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= bgfd_pkg::PH_HUNT1;
         cur_class_ff  <= 8'd0;
         cur_id_ff     <= 8'd0;
         cur_len_ff    <= 16'd0;
         bytes_seen_ff <= 16'd0;
         sum_a_ff      <= 8'd0;
         sum_b_ff      <= 8'd0;
         rx_check_a_ff <= 8'd0;
         good_count_ff <= 32'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         cur_class_ff  <= cur_class_in;
         cur_id_ff     <= cur_id_in;
         cur_len_ff    <= cur_len_in;
         bytes_seen_ff <= bytes_seen_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         rx_check_a_ff <= rx_check_a_in;
         good_count_ff <= good_count_in;
      end
   end

   // Output register with skid. While the skid is full no transaction is
   // accepted, so the skid drains into the output before new results arrive.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff || (accept && res_valid);
         skid_valid_ff <= 1'b0;
      end else if (accept && res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= skid_valid_ff ? skid_ff : res;
      end else if (accept && res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_frame_end = rsp_ff.is_frame_end;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_byte_index   = rsp_ff.byte_index;
   assign rsp_msg_class    = rsp_ff.msg_class;
   assign rsp_msg_id       = rsp_ff.msg_id;
   assign rsp_payload_len  = rsp_ff.payload_len;
   assign rsp_frame_status = rsp_ff.frame_status;
   assign rsp_good_frames  = rsp_ff.good_frames;

   // skid only ever fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result with output register empty");

   // second checksum byte always yields a pending result
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == bgfd_pkg::PH_CK_B) |=> rsp_valid_ff)
      else $error("end-of-frame result lost");

   // payload phase only runs with bytes still owed
   a_payload_bounds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bgfd_pkg::PH_PAYLOAD) |-> (bytes_seen_ff < cur_len_ff))
      else $error("payload phase past header length");

   // good-frame count steps by at most one
   a_good_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (good_count_ff == $past(good_count_ff)) ||
               (good_count_ff == $past(good_count_ff) + 32'd1))
      else $error("good-frame count jumped");

endmodule
